FILE: sv/plix_pkg.sv
// shared types, constants and state codes of the piecewise linear interpolator
package plix_pkg;

    localparam int MAX_POINTS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int WORD_W    = 32;
    localparam int MAG_W     = 33;
    localparam int ALU_W     = 35;
    localparam int CNT_W     = 6;
    localparam int PC_W      = 5;
    localparam int PC_RESET  = 2;

    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 3;

    // iteration counts of the shared unit
    localparam int SLOPE_STEPS = 32;
    localparam int VALUE_STEPS = 33;
    localparam int MUL_STEPS   = 33;

    localparam logic [WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] INT_MIN = 32'h8000_0000;
    // quotient magnitude that saturates any 32-bit result
    localparam logic [ALU_W-1:0]  SAT_MAG = {2'b01, 33'd0};

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } t_alu_op;

    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;
    } t_alu_rsp;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_EVAL = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_BELOW    = 2'd1,
        REGION_ABOVE    = 2'd2
    } t_region;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRCH,
        S_GET_HI,
        S_GET_LO,
        S_DY,
        S_T,
        S_ABS_DX,
        S_ABS_DY,
        S_ABS_T,
        S_SL_SET,
        S_DIV,
        S_SL_FIN,
        S_MUL,
        S_V_SET,
        S_V_FIN,
        S_DONE
    } t_state;

endpackage

FILE: sv/plix_alu.sv
// shared add/subtract unit with unsigned borrow, used for compare, multiply and divide steps
module plix_alu (
    input  plix_pkg::t_alu_req i_req,
    output plix_pkg::t_alu_rsp o_rsp
);

    logic [plix_pkg::ALU_W-1:0] w_b;
    logic                       w_cin;
    logic [plix_pkg::ALU_W:0]   w_sum;

    always_comb begin
        case (i_req.op)
            plix_pkg::ALU_ADD: begin
                w_b   = i_req.b;
                w_cin = 1'b0;
            end
            plix_pkg::ALU_SUB: begin
                w_b   = ~i_req.b;
                w_cin = 1'b1;
            end
            default: begin
                w_b   = i_req.b;
                w_cin = 1'b0;
            end
        endcase
    end

    assign w_sum = {1'b0, i_req.a} + {1'b0, w_b} + {{plix_pkg::ALU_W{1'b0}}, w_cin};

    assign o_rsp.res    = w_sum[plix_pkg::ALU_W-1:0];
    // no carry out of a subtract means a < b
    assign o_rsp.borrow = ~w_sum[plix_pkg::ALU_W];

endmodule

FILE: sv/plix_table.sv
// breakpoint memory: key and value arrays, one write port, one registered read port
module plix_table #(
    parameter  int DEPTH = plix_pkg::MAX_POINTS_DEF,
    localparam int IW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [IW-1:0]               i_wr_addr,
    input  logic [plix_pkg::WORD_W-1:0] i_wr_key,
    input  logic [plix_pkg::WORD_W-1:0] i_wr_value,
    input  logic [IW-1:0]               i_rd_addr,
    output logic [plix_pkg::WORD_W-1:0] o_rd_key,
    output logic [plix_pkg::WORD_W-1:0] o_rd_value
);

    logic [plix_pkg::WORD_W-1:0] r_keys   [DEPTH];
    logic [plix_pkg::WORD_W-1:0] r_values [DEPTH];
    logic [plix_pkg::WORD_W-1:0] r_rd_key;
    logic [plix_pkg::WORD_W-1:0] r_rd_value;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_keys[i_wr_addr]   <= i_wr_key;
            r_values[i_wr_addr] <= i_wr_value;
        end
        r_rd_key   <= r_keys[i_rd_addr];
        r_rd_value <= r_values[i_rd_addr];
    end

    assign o_rd_key   = r_rd_key;
    assign o_rd_value = r_rd_value;

endmodule

FILE: sv/piecewise_linear_interpolator_unit.sv
// piecewise linear interpolator top level: sequencer around the shared unit and the breakpoint memory
//
//  channel  dir  handshake                          payload (lowest bits first)
//  s_axis   in   i_s_axis_tvalid/o_s_axis_tready    tdata: point_index, key, value, query
//                                                   tuser: command
//  m_axis   out  o_m_axis_tvalid/i_m_axis_tready    tdata: result_value, result_slope
//                                                   tuser: region, segment_error
//  cfg      in   i_cfg_wr_en                        i_cfg_wr_data: point_count
//
// a load is written into the table when it is taken. an evaluate scans the keys, reads the two
// breakpoints of its segment and finds the slope; when clamped it returns the end value, and in
// the interior it goes on to the interpolated value. a zero-width segment finishes once its
// differences are formed, and an overflowing quotient skips its divide steps. it all runs on the
// one add/subtract unit: 32 divide steps for the slope, 33 multiply and 33 divide for the value.
// reset is synchronous, active low; it clears the sequencer, point_count (to 2) and the
// output valid. the result waits in an output register, and loads are taken meanwhile.
module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS = plix_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = plix_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [plix_pkg::PC_W-1:0]      i_cfg_wr_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // point_index[3:0], key[35:4], value[67:36], query[99:68], zeros above
    input  logic [plix_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    // command[0]
    input  logic [plix_pkg::S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // result_value[31:0], result_slope[63:32]
    output logic [plix_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // region[1:0], segment_error[2]
    output logic [plix_pkg::M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int W  = plix_pkg::WORD_W;
    localparam int AW = plix_pkg::ALU_W;
    localparam int MW = plix_pkg::MAG_W;

    function automatic logic [AW-1:0] f_sext(input logic [W-1:0] v);
        return {{(AW-W){v[W-1]}}, v};
    endfunction

    function automatic logic [W-1:0] f_sat32(input logic [AW-1:0] v);
        logic [AW-W:0] top;
        top = v[AW-1:W-1];
        if (top == '0 || top == '1) begin
            return v[W-1:0];
        end
        return v[AW-1] ? plix_pkg::INT_MIN : plix_pkg::INT_MAX;
    endfunction

    // input fields
    logic [3:0]         w_pidx;
    logic [W-1:0]       w_key;
    logic [W-1:0]       w_value;
    logic [W-1:0]       w_query;
    plix_pkg::t_cmd     w_cmd;
    logic               w_s_acc;
    logic [IW+3:0]      w_slot_wide;
    logic [IW-1:0]      w_wr_addr;
    logic               w_slot_ok;
    logic               w_load;
    logic [31:0]        w_pc32;
    logic [31:0]        w_last32;
    logic [IW-1:0]      w_last;
    logic [63:0]        w_shifted;
    logic [AW-1:0]      w_rem2;
    logic [AW-1:0]      w_fin_mag;

    // table read side
    logic [IW-1:0]      n_rd_addr;
    logic [W-1:0]       w_rd_key;
    logic [W-1:0]       w_rd_value;

    plix_pkg::t_alu_req w_alu_req;
    plix_pkg::t_alu_rsp w_alu_rsp;

    plix_pkg::t_state   r_state, n_state;
    logic [plix_pkg::PC_W-1:0] r_point_count;
    logic [W-1:0]       r_query, n_query;
    logic [IW-1:0]      r_last, n_last;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_lo_idx, n_lo_idx;
    plix_pkg::t_region  r_region, n_region;
    logic [W-1:0]       r_x1, n_x1;
    logic [W-1:0]       r_y1, n_y1;
    logic [W-1:0]       r_x0, n_x0;
    logic [W-1:0]       r_y0, n_y0;
    logic [AW-1:0]      r_dx, n_dx;
    logic [AW-1:0]      r_dy, n_dy;
    logic [AW-1:0]      r_t, n_t;
    logic               r_neg_dx, n_neg_dx;
    logic               r_neg_dy, n_neg_dy;
    logic               r_neg_t, n_neg_t;
    logic [AW-1:0]      r_rem, n_rem;
    logic [MW-1:0]      r_lo, n_lo;
    logic [MW-1:0]      r_quo, n_quo;
    logic [plix_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic               r_over, n_over;
    logic               r_is_val, n_is_val;
    logic [W-1:0]       r_slope, n_slope;
    logic [W-1:0]       r_val, n_val;
    logic               r_err, n_err;
    logic               r_out_valid, n_out_valid;
    logic [W-1:0]       r_out_value, n_out_value;
    logic [W-1:0]       r_out_slope, n_out_slope;
    plix_pkg::t_region  r_out_region, n_out_region;
    logic               r_out_err, n_out_err;

    assign w_pidx  = i_s_axis_tdata[3:0];
    assign w_key   = i_s_axis_tdata[35:4];
    assign w_value = i_s_axis_tdata[67:36];
    assign w_query = i_s_axis_tdata[99:68];
    assign w_cmd   = plix_pkg::t_cmd'(i_s_axis_tuser[0]);

    assign o_s_axis_tready = (r_state == plix_pkg::S_IDLE);
    assign w_s_acc         = i_s_axis_tvalid && o_s_axis_tready;

    assign w_slot_wide = {{IW{1'b0}}, w_pidx};
    assign w_wr_addr   = w_slot_wide[IW-1:0];
    assign w_slot_ok   = ({28'd0, w_pidx} < 32'(MAX_POINTS));
    assign w_load      = w_s_acc && (w_cmd == plix_pkg::CMD_LOAD) && w_slot_ok;

    // index of the last breakpoint in use, count clamped to [2, MAX_POINTS]
    assign w_pc32   = {27'd0, r_point_count};
    assign w_last32 = (w_pc32 < 32'd2) ? 32'd1 :
                      (w_pc32 > 32'(MAX_POINTS)) ? 32'(MAX_POINTS - 1) : w_pc32 - 32'd1;
    assign w_last   = w_last32[IW-1:0];

    // slope dividend |dy| << FRAC_BITS
    assign w_shifted = {31'd0, r_dy[MW-1:0]} << FRAC_BITS;
    assign w_rem2    = {r_rem[AW-2:0], r_lo[MW-1]};
    assign w_fin_mag = r_over ? plix_pkg::SAT_MAG : {{(AW-MW){1'b0}}, r_quo};

    plix_table #(
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (w_load),
        .i_wr_addr  (w_wr_addr),
        .i_wr_key   (w_key),
        .i_wr_value (w_value),
        .i_rd_addr  (n_rd_addr),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_value)
    );

    plix_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= plix_pkg::S_IDLE;
            r_point_count <= plix_pkg::PC_W'(plix_pkg::PC_RESET);
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_point_count <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_query      <= n_query;
        r_last       <= n_last;
        r_idx        <= n_idx;
        r_lo_idx     <= n_lo_idx;
        r_region     <= n_region;
        r_x1         <= n_x1;
        r_y1         <= n_y1;
        r_x0         <= n_x0;
        r_y0         <= n_y0;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_t          <= n_t;
        r_neg_dx     <= n_neg_dx;
        r_neg_dy     <= n_neg_dy;
        r_neg_t      <= n_neg_t;
        r_rem        <= n_rem;
        r_lo         <= n_lo;
        r_quo        <= n_quo;
        r_cnt        <= n_cnt;
        r_over       <= n_over;
        r_is_val     <= n_is_val;
        r_slope      <= n_slope;
        r_val        <= n_val;
        r_err        <= n_err;
        r_out_value  <= n_out_value;
        r_out_slope  <= n_out_slope;
        r_out_region <= n_out_region;
        r_out_err    <= n_out_err;
    end

    always_comb begin
        n_state      = r_state;
        n_query      = r_query;
        n_last       = r_last;
        n_idx        = r_idx;
        n_lo_idx     = r_lo_idx;
        n_region     = r_region;
        n_x1         = r_x1;
        n_y1         = r_y1;
        n_x0         = r_x0;
        n_y0         = r_y0;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_t          = r_t;
        n_neg_dx     = r_neg_dx;
        n_neg_dy     = r_neg_dy;
        n_neg_t      = r_neg_t;
        n_rem        = r_rem;
        n_lo         = r_lo;
        n_quo        = r_quo;
        n_cnt        = r_cnt;
        n_over       = r_over;
        n_is_val     = r_is_val;
        n_slope      = r_slope;
        n_val        = r_val;
        n_err        = r_err;
        n_out_valid  = r_out_valid;
        n_out_value  = r_out_value;
        n_out_slope  = r_out_slope;
        n_out_region = r_out_region;
        n_out_err    = r_out_err;
        n_rd_addr    = r_idx;
        w_alu_req.op = plix_pkg::ALU_SUB;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            plix_pkg::S_IDLE: begin
                n_rd_addr = '0;
                if (w_s_acc && w_cmd == plix_pkg::CMD_EVAL) begin
                    n_query = w_query;
                    n_last  = w_last;
                    n_idx   = '0;
                    n_state = plix_pkg::S_SRCH;
                end
            end
            plix_pkg::S_SRCH: begin
                // signed compare as unsigned with sign bits flipped: key >= query
                w_alu_req.a = {{(AW-W){1'b0}}, ~w_rd_key[W-1], w_rd_key[W-2:0]};
                w_alu_req.b = {{(AW-W){1'b0}}, ~r_query[W-1], r_query[W-2:0]};
                if (!w_alu_rsp.borrow) begin
                    if (r_idx == '0) begin
                        n_region  = plix_pkg::REGION_BELOW;
                        n_rd_addr = IW'(1);
                        n_lo_idx  = '0;
                    end else begin
                        n_region  = plix_pkg::REGION_INTERIOR;
                        n_rd_addr = r_idx;
                        n_lo_idx  = r_idx - 1'b1;
                    end
                    n_state = plix_pkg::S_GET_HI;
                end else if (r_idx == r_last) begin
                    n_region  = plix_pkg::REGION_ABOVE;
                    n_rd_addr = r_last;
                    n_lo_idx  = r_last - 1'b1;
                    n_state   = plix_pkg::S_GET_HI;
                end else begin
                    n_idx     = r_idx + 1'b1;
                    n_rd_addr = r_idx + 1'b1;
                end
            end
            plix_pkg::S_GET_HI: begin
                n_x1      = w_rd_key;
                n_y1      = w_rd_value;
                n_rd_addr = r_lo_idx;
                n_state   = plix_pkg::S_GET_LO;
            end
            plix_pkg::S_GET_LO: begin
                w_alu_req.a = f_sext(r_x1);
                w_alu_req.b = f_sext(w_rd_key);
                n_dx        = w_alu_rsp.res;
                n_x0        = w_rd_key;
                n_y0        = w_rd_value;
                n_state     = plix_pkg::S_DY;
            end
            plix_pkg::S_DY: begin
                w_alu_req.a = f_sext(r_y1);
                w_alu_req.b = f_sext(r_y0);
                n_dy        = w_alu_rsp.res;
                n_state     = plix_pkg::S_T;
            end
            plix_pkg::S_T: begin
                w_alu_req.a = f_sext(r_query);
                w_alu_req.b = f_sext(r_x0);
                n_t         = w_alu_rsp.res;
                if (r_dx == '0) begin
                    // zero-width segment
                    n_slope = '0;
                    n_val   = '0;
                    n_err   = 1'b1;
                    n_state = plix_pkg::S_DONE;
                end else begin
                    n_state = plix_pkg::S_ABS_DX;
                end
            end
            plix_pkg::S_ABS_DX: begin
                w_alu_req.b = r_dx;
                n_neg_dx    = r_dx[AW-1];
                if (r_dx[AW-1]) begin
                    n_dx = w_alu_rsp.res;
                end
                n_state = plix_pkg::S_ABS_DY;
            end
            plix_pkg::S_ABS_DY: begin
                w_alu_req.b = r_dy;
                n_neg_dy    = r_dy[AW-1];
                if (r_dy[AW-1]) begin
                    n_dy = w_alu_rsp.res;
                end
                n_state = plix_pkg::S_ABS_T;
            end
            plix_pkg::S_ABS_T: begin
                w_alu_req.b = r_t;
                n_neg_t     = r_t[AW-1];
                if (r_t[AW-1]) begin
                    n_t = w_alu_rsp.res;
                end
                n_state = plix_pkg::S_SL_SET;
            end
            plix_pkg::S_SL_SET: begin
                // quotient of 2^32 or more saturates, so only 32 quotient bits are made
                w_alu_req.a = {{(AW-W){1'b0}}, w_shifted[63:32]};
                w_alu_req.b = r_dx;
                n_rem       = {{(AW-W){1'b0}}, w_shifted[63:32]};
                n_lo        = {w_shifted[31:0], 1'b0};
                n_quo       = '0;
                n_cnt       = plix_pkg::CNT_W'(plix_pkg::SLOPE_STEPS);
                n_is_val    = 1'b0;
                n_over      = !w_alu_rsp.borrow;
                n_state     = w_alu_rsp.borrow ? plix_pkg::S_DIV : plix_pkg::S_SL_FIN;
            end
            plix_pkg::S_DIV: begin
                w_alu_req.a = w_rem2;
                w_alu_req.b = r_dx;
                n_rem       = w_alu_rsp.borrow ? w_rem2 : w_alu_rsp.res;
                n_quo       = {r_quo[MW-2:0], !w_alu_rsp.borrow};
                n_lo        = {r_lo[MW-2:0], 1'b0};
                n_cnt       = r_cnt - 1'b1;
                if (r_cnt == plix_pkg::CNT_W'(1)) begin
                    n_state = r_is_val ? plix_pkg::S_V_FIN : plix_pkg::S_SL_FIN;
                end
            end
            plix_pkg::S_SL_FIN: begin
                w_alu_req.op = (r_neg_dy ^ r_neg_dx) ? plix_pkg::ALU_SUB : plix_pkg::ALU_ADD;
                w_alu_req.b  = w_fin_mag;
                n_slope      = f_sat32(w_alu_rsp.res);
                n_err        = 1'b0;
                case (r_region)
                    plix_pkg::REGION_BELOW: begin
                        n_val   = r_y0;
                        n_state = plix_pkg::S_DONE;
                    end
                    plix_pkg::REGION_ABOVE: begin
                        n_val   = r_y1;
                        n_state = plix_pkg::S_DONE;
                    end
                    default: begin
                        n_rem   = '0;
                        n_lo    = r_t[MW-1:0];
                        n_cnt   = plix_pkg::CNT_W'(plix_pkg::MUL_STEPS);
                        n_state = plix_pkg::S_MUL;
                    end
                endcase
            end
            plix_pkg::S_MUL: begin
                // shift-add: high half in r_rem, multiplier shifts out of r_lo
                w_alu_req.op = plix_pkg::ALU_ADD;
                w_alu_req.a  = r_rem;
                w_alu_req.b  = r_lo[0] ? {{(AW-MW){1'b0}}, r_dy[MW-1:0]} : '0;
                n_rem        = {1'b0, w_alu_rsp.res[AW-1:1]};
                n_lo         = {w_alu_rsp.res[0], r_lo[MW-1:1]};
                n_cnt        = r_cnt - 1'b1;
                if (r_cnt == plix_pkg::CNT_W'(1)) begin
                    n_state = plix_pkg::S_V_SET;
                end
            end
            plix_pkg::S_V_SET: begin
                // a term of 2^33 or more saturates the sum
                w_alu_req.a = r_rem;
                w_alu_req.b = r_dx;
                n_quo       = '0;
                n_cnt       = plix_pkg::CNT_W'(plix_pkg::VALUE_STEPS);
                n_is_val    = 1'b1;
                n_over      = !w_alu_rsp.borrow;
                n_state     = w_alu_rsp.borrow ? plix_pkg::S_DIV : plix_pkg::S_V_FIN;
            end
            plix_pkg::S_V_FIN: begin
                w_alu_req.op = (r_neg_dy ^ r_neg_dx ^ r_neg_t) ?
                               plix_pkg::ALU_SUB : plix_pkg::ALU_ADD;
                w_alu_req.a  = f_sext(r_y0);
                w_alu_req.b  = w_fin_mag;
                n_val        = f_sat32(w_alu_rsp.res);
                n_state      = plix_pkg::S_DONE;
            end
            plix_pkg::S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = r_val;
                    n_out_slope  = r_slope;
                    n_out_region = r_region;
                    n_out_err    = r_err;
                    n_state      = plix_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = plix_pkg::S_IDLE;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_slope, r_out_value};
    assign o_m_axis_tuser  = {r_out_err, r_out_region};

    a_eval_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_cmd == plix_pkg::CMD_EVAL) |=> !o_s_axis_tready)
        else $error("input taken while an evaluate is in progress");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[2]) |-> (o_m_axis_tdata == '0))
        else $error("segment error item carries nonzero value or slope");

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plix_pkg::S_MUL) |-> (r_rem[AW-1:AW-2] == 2'b00))
        else $error("multiply accumulator out of range");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plix_pkg::S_DIV) |-> (r_rem < r_dx))
        else $error("partial remainder not below divisor");

endmodule
